[hdl/bdal_pkg.sv]
// Shared constants and types for the baseline displacement alarm.
package bdal_pkg;

  // Coordinate and displacement width (fixed by the point format)
  localparam int unsigned COORD_BITS = 16;
  // Width of the per-frame count result fields
  localparam int unsigned CNT_OUT_W = 13;
  // Default frame capacity in points
  localparam int unsigned DEF_MAX_FRAME_POINTS = 4096;

  // Ratio arithmetic
  localparam int unsigned PERMILLE_W = 10;
  localparam logic [PERMILLE_W-1:0] PERMILLE_SCALE = 10'd1000;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DISP_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_PERMILLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_PERMILLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_FRAMES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_FRAMES  = 3'd4;

  // Register reset values
  localparam logic [COORD_BITS-1:0] RST_DISP_THRESHOLD   = '0;
  localparam logic [PERMILLE_W-1:0] RST_TRIGGER_PERMILLE = 10'd50;
  localparam logic [PERMILLE_W-1:0] RST_CLEAR_PERMILLE   = 10'd20;
  localparam logic [3:0]            RST_DEBOUNCE_FRAMES  = 4'd3;
  localparam logic [7:0]            RST_BASELINE_FRAMES  = 8'd100;

  // Request kinds
  localparam logic REQ_POINT      = 1'b0;
  localparam logic REQ_REBASELINE = 1'b1;

  // Alarm event codes
  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_RAISED  = 2'd1,
    EVT_CLEARED = 2'd2
  } alarm_event_e;

  // Sequencer states
  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_POINT  = 10'b00_0000_0010,
    ST_EVAL   = 10'b00_0000_0100,
    ST_CLOSE  = 10'b00_0000_1000,
    ST_DIV    = 10'b00_0001_0000,
    ST_MUL_L  = 10'b00_0010_0000,
    ST_MUL_T  = 10'b00_0100_0000,
    ST_MUL_C  = 10'b00_1000_0000,
    ST_DECIDE = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } seq_state_e;

  // Divider handshake towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hdl/bdal_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module bdal_div #(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  output bdal_pkg::div_status_t status_o,
  output logic [NUM_W-1:0]     quot_o
);
  import bdal_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;
  logic              done_q;
  logic [DEN_W:0]    rem_shift;
  logic              fits;
  logic [DEN_W:0]    rem_diff;

  // Bring down the next dividend bit and trial-subtract
  assign rem_shift = {rem_q, num_q[NUM_W-1]};
  assign fits      = rem_shift >= {1'b0, den_q};
  assign rem_diff  = rem_shift - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= STEP_W'(NUM_W);
      end else if (step_q != '0) begin
        step_q <= step_q - STEP_W'(1);
        done_q <= (step_q == STEP_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (step_q != '0) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    end
  end

  assign status_o.busy = (step_q != '0);
  assign status_o.done = done_q;
  assign quot_o        = num_q;

endmodule

[hdl/baseline_displacement_alarm_unit.sv]
// Top level of the baseline displacement alarm: point sequencer, ratio checks and alarm.
//
// Radar points enter one item at a time on the in channel; last_in_frame_i closes a frame and
// the frame's result item leaves on the out channel. While the baseline is collected a point
// passes accept and baseline sum steps; once it is established it passes accept, displacement
// subtract, and threshold and maximum compare; the sequencer walks these steps and holds
// in_ready_o low meanwhile. A closing point then passes close and emit while the baseline is
// collected, and close, three multiplier steps, decision and emit once it is established:
// the ratio test runs the anomaly*1000 and permille*points products one after another
// through a single shared multiplier, then a decision step updates the debounce runs and the
// alarm. The frame that completes the baseline also runs the reference division on an
// iterative divider, one quotient bit per cycle over COORD_BITS + clog2(MAX_FRAME_POINTS + 1)
// + 8 bits (37 at the defaults), before its emit step. Results sit in an output register, so
// the next item is taken while a result waits; only a further frame close holds in its emit
// step until that register is free. A rebaseline item clears the baseline, alarm and frame
// state at once and returns no result. Configuration writes are always taken (cfg_ready_o is
// tied high) and are expected only while the block is idle.
module baseline_displacement_alarm_unit #(
  parameter int unsigned MAX_FRAME_POINTS = bdal_pkg::DEF_MAX_FRAME_POINTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bdal_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bdal_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // point channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic signed [bdal_pkg::COORD_BITS-1:0] point_x_i,
  input  logic signed [bdal_pkg::COORD_BITS-1:0] point_y_i,
  input  logic signed [bdal_pkg::COORD_BITS-1:0] point_z_i,
  input  logic                                last_in_frame_i,
  // frame result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          alarm_event_o,
  output logic                                alarm_active_o,
  output logic                                baseline_done_o,
  output logic signed [bdal_pkg::COORD_BITS-1:0] reference_height_o,
  output logic [bdal_pkg::COORD_BITS-1:0]     frame_max_disp_o,
  output logic signed [bdal_pkg::COORD_BITS-1:0] worst_x_o,
  output logic signed [bdal_pkg::COORD_BITS-1:0] worst_y_o,
  output logic signed [bdal_pkg::COORD_BITS-1:0] worst_z_o,
  output logic [bdal_pkg::CNT_OUT_W-1:0]      anomaly_count_o,
  output logic [bdal_pkg::CNT_OUT_W-1:0]      frame_points_o,
  output logic                                frame_overflow_o
);
  import bdal_pkg::*;

  // Per-frame counters hold up to MAX_FRAME_POINTS; the baseline spans up to 255 frames
  localparam int unsigned CNT_W  = $clog2(MAX_FRAME_POINTS + 1);
  localparam int unsigned BLC_W  = CNT_W + 8;
  localparam int unsigned SUM_W  = COORD_BITS + BLC_W;
  localparam int unsigned PROD_W = CNT_W + PERMILLE_W;
  localparam logic [CNT_W-1:0] MAX_PTS = CNT_W'(MAX_FRAME_POINTS);

  // configuration registers
  logic [COORD_BITS-1:0] disp_thr_q;
  logic [PERMILLE_W-1:0] trig_pm_q;
  logic [PERMILLE_W-1:0] clr_pm_q;
  logic [3:0]            deb_frames_q;
  logic [7:0]            bl_frames_q;

  // sequencer and latched item
  seq_state_e            state_q;
  logic signed [COORD_BITS-1:0] x_q, y_q, z_q;
  logic                  last_q;

  // baseline and alarm state
  logic                  bl_ready_q;
  logic [7:0]            bl_frame_cnt_q;
  logic [SUM_W-1:0]      bl_sum_q;
  logic [BLC_W-1:0]      bl_pt_cnt_q;
  logic [COORD_BITS-1:0] ref_q;
  logic                  alarm_q;
  logic [3:0]            trig_run_q, clr_run_q;

  // current frame
  logic [CNT_W-1:0]      cur_pts_q;
  logic [CNT_W-1:0]      cur_anom_q;
  logic [COORD_BITS-1:0] cur_max_q;
  logic [COORD_BITS-1:0] worst_x_q, worst_y_q, worst_z_q;
  logic                  cur_ovf_q;

  // working registers
  logic [COORD_BITS-1:0] disp_q;
  logic [PROD_W-1:0]     lhs_q;
  logic                  trig_hit_q, clr_hit_q;
  logic [1:0]            event_q;
  logic                  div_neg_q;

  // output register
  logic                  out_valid_q;
  logic [1:0]            o_event_q;
  logic                  o_alarm_q, o_bl_done_q, o_ovf_q;
  logic [COORD_BITS-1:0] o_ref_q, o_max_q, o_wx_q, o_wy_q, o_wz_q;
  logic [CNT_W-1:0]      o_anom_q, o_pts_q;

  // combinational helpers
  logic                  in_accept;
  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0]   diff_abs;
  logic [CNT_W-1:0]      mul_a;
  logic [PERMILLE_W-1:0] mul_b;
  logic [PROD_W-1:0]     prod;
  logic [7:0]            bl_frame_cnt_d;
  logic [7:0]            bl_need;
  logic [SUM_W-1:0]      bl_mag;
  logic                  div_start;
  div_status_t           div_status;
  logic [SUM_W-1:0]      div_quot;
  logic [SUM_W-1:0]      ref_full;
  logic [3:0]            deb_need;
  logic [3:0]            trig_run_d, clr_run_d;
  logic                  raise, drop, alarm_mid;
  logic [1:0]            event_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;

  // configuration writes; unknown indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_thr_q   <= RST_DISP_THRESHOLD;
      trig_pm_q    <= RST_TRIGGER_PERMILLE;
      clr_pm_q     <= RST_CLEAR_PERMILLE;
      deb_frames_q <= RST_DEBOUNCE_FRAMES;
      bl_frames_q  <= RST_BASELINE_FRAMES;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DISP_THRESHOLD:   disp_thr_q   <= cfg_data_i[COORD_BITS-1:0];
        REG_TRIGGER_PERMILLE: trig_pm_q    <= cfg_data_i[PERMILLE_W-1:0];
        REG_CLEAR_PERMILLE:   clr_pm_q     <= cfg_data_i[PERMILLE_W-1:0];
        REG_DEBOUNCE_FRAMES:  deb_frames_q <= cfg_data_i[3:0];
        REG_BASELINE_FRAMES:  bl_frames_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // displacement from the reference, one extra bit so the magnitude never wraps
  assign diff     = $signed({z_q[COORD_BITS-1], z_q}) - $signed({ref_q[COORD_BITS-1], ref_q});
  assign diff_abs = diff[COORD_BITS] ? (~diff + 1'b1) : diff;

  // shared multiplier: anomaly scale, then trigger and clear thresholds
  always_comb begin
    mul_a = cur_pts_q;
    mul_b = trig_pm_q;
    unique case (state_q)
      ST_MUL_L: begin
        mul_a = cur_anom_q;
        mul_b = PERMILLE_SCALE;
      end
      ST_MUL_C: mul_b = clr_pm_q;
      default:  mul_b = trig_pm_q;
    endcase
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // baseline frame bookkeeping; zero frames acts as one
  assign bl_frame_cnt_d = (bl_frame_cnt_q == 8'hFF) ? bl_frame_cnt_q : bl_frame_cnt_q + 8'd1;
  assign bl_need        = (bl_frames_q == 8'd0) ? 8'd1 : bl_frames_q;
  assign bl_mag         = bl_sum_q[SUM_W-1] ? (~bl_sum_q + 1'b1) : bl_sum_q;
  assign div_start      = (state_q == ST_CLOSE) && !bl_ready_q && (bl_frame_cnt_d >= bl_need)
                          && (bl_pt_cnt_q != '0);
  assign ref_full       = div_neg_q ? (~div_quot + 1'b1) : div_quot;

  bdal_div #(
    .NUM_W (SUM_W),
    .DEN_W (BLC_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (bl_mag),
    .den_i    (bl_pt_cnt_q),
    .status_o (div_status),
    .quot_o   (div_quot)
  );

  // debounce: runs saturate at 15, zero debounce acts as one; raise then clear in one frame
  assign deb_need   = (deb_frames_q == 4'd0) ? 4'd1 : deb_frames_q;
  assign trig_run_d = trig_hit_q ? ((trig_run_q == 4'hF) ? trig_run_q : trig_run_q + 4'd1)
                                 : 4'd0;
  assign clr_run_d  = clr_hit_q ? ((clr_run_q == 4'hF) ? clr_run_q : clr_run_q + 4'd1) : 4'd0;
  assign raise      = !alarm_q && (trig_run_d >= deb_need);
  assign alarm_mid  = alarm_q || raise;
  assign drop       = alarm_mid && (clr_run_d >= deb_need);
  always_comb begin
    priority if (drop) begin
      event_d = EVT_CLEARED;
    end else if (raise) begin
      event_d = EVT_RAISED;
    end else begin
      event_d = EVT_NONE;
    end
  end

  // sequencer with the baseline, alarm, frame and output-valid state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      bl_ready_q     <= 1'b0;
      bl_frame_cnt_q <= '0;
      bl_sum_q       <= '0;
      bl_pt_cnt_q    <= '0;
      ref_q          <= '0;
      alarm_q        <= 1'b0;
      trig_run_q     <= '0;
      clr_run_q      <= '0;
      cur_pts_q      <= '0;
      cur_anom_q     <= '0;
      cur_max_q      <= '0;
      worst_x_q      <= '0;
      worst_y_q      <= '0;
      worst_z_q      <= '0;
      cur_ovf_q      <= 1'b0;
      event_q        <= EVT_NONE;
      out_valid_q    <= 1'b0;
    end else begin
      // the emit step refills the output register itself
      if (out_valid_q && out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (req_type_i == REQ_REBASELINE) begin
              // restart everything, registers kept
              bl_ready_q     <= 1'b0;
              bl_frame_cnt_q <= '0;
              bl_sum_q       <= '0;
              bl_pt_cnt_q    <= '0;
              ref_q          <= '0;
              alarm_q        <= 1'b0;
              trig_run_q     <= '0;
              clr_run_q      <= '0;
              cur_pts_q      <= '0;
              cur_anom_q     <= '0;
              cur_max_q      <= '0;
              worst_x_q      <= '0;
              worst_y_q      <= '0;
              worst_z_q      <= '0;
              cur_ovf_q      <= 1'b0;
            end else begin
              state_q <= ST_POINT;
            end
          end
        end
        ST_POINT: begin
          if (cur_pts_q == MAX_PTS) begin
            // frame full: flag and drop the point
            cur_ovf_q <= 1'b1;
            state_q   <= last_q ? ST_CLOSE : ST_IDLE;
          end else begin
            cur_pts_q <= cur_pts_q + CNT_W'(1);
            if (!bl_ready_q) begin
              bl_sum_q    <= bl_sum_q + {{(SUM_W-COORD_BITS){z_q[COORD_BITS-1]}}, z_q};
              bl_pt_cnt_q <= bl_pt_cnt_q + BLC_W'(1);
              state_q     <= last_q ? ST_CLOSE : ST_IDLE;
            end else begin
              disp_q  <= diff_abs[COORD_BITS-1:0];
              state_q <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          if (disp_q > disp_thr_q) begin
            cur_anom_q <= cur_anom_q + CNT_W'(1);
            if (disp_q > cur_max_q) begin
              cur_max_q <= disp_q;
              worst_x_q <= x_q;
              worst_y_q <= y_q;
              worst_z_q <= z_q;
            end
          end
          state_q <= last_q ? ST_CLOSE : ST_IDLE;
        end
        ST_CLOSE: begin
          if (!bl_ready_q) begin
            event_q        <= EVT_NONE;
            bl_frame_cnt_q <= bl_frame_cnt_d;
            if (bl_frame_cnt_d >= bl_need) begin
              if (bl_pt_cnt_q != '0) begin
                state_q <= ST_DIV;
              end else begin
                ref_q      <= '0;
                bl_ready_q <= 1'b1;
                state_q    <= ST_EMIT;
              end
            end else begin
              state_q <= ST_EMIT;
            end
          end else begin
            state_q <= ST_MUL_L;
          end
        end
        ST_DIV: begin
          if (div_status.done) begin
            ref_q      <= ref_full[COORD_BITS-1:0];
            bl_ready_q <= 1'b1;
            state_q    <= ST_EMIT;
          end
        end
        ST_MUL_L: state_q <= ST_MUL_T;
        ST_MUL_T: state_q <= ST_MUL_C;
        ST_MUL_C: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          trig_run_q <= trig_run_d;
          clr_run_q  <= clr_run_d;
          alarm_q    <= alarm_mid && !drop;
          event_q    <= event_d;
          state_q    <= ST_EMIT;
        end
        ST_EMIT: begin
          // hand the frame over once the output register is free, then clear the frame
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            cur_pts_q   <= '0;
            cur_anom_q  <= '0;
            cur_max_q   <= '0;
            worst_x_q   <= '0;
            worst_y_q   <= '0;
            worst_z_q   <= '0;
            cur_ovf_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers: latched item, ratio products, result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q    <= point_x_i;
      y_q    <= point_y_i;
      z_q    <= point_z_i;
      last_q <= last_in_frame_i;
    end
    if (div_start) begin
      div_neg_q <= bl_sum_q[SUM_W-1];
    end
    if (state_q == ST_MUL_L) begin
      lhs_q <= prod;
    end
    if (state_q == ST_MUL_T) begin
      trig_hit_q <= lhs_q > prod;
    end
    if (state_q == ST_MUL_C) begin
      clr_hit_q <= lhs_q < prod;
    end
    if ((state_q == ST_EMIT) && (!out_valid_q || out_ready_i)) begin
      o_event_q   <= event_q;
      o_alarm_q   <= alarm_q;
      o_bl_done_q <= bl_ready_q;
      o_ref_q     <= ref_q;
      o_max_q     <= cur_max_q;
      o_wx_q      <= worst_x_q;
      o_wy_q      <= worst_y_q;
      o_wz_q      <= worst_z_q;
      o_anom_q    <= cur_anom_q;
      o_pts_q     <= cur_pts_q;
      o_ovf_q     <= cur_ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign alarm_event_o      = o_event_q;
  assign alarm_active_o     = o_alarm_q;
  assign baseline_done_o    = o_bl_done_q;
  assign reference_height_o = o_ref_q;
  assign frame_max_disp_o   = o_max_q;
  assign worst_x_o          = o_wx_q;
  assign worst_y_o          = o_wy_q;
  assign worst_z_o          = o_wz_q;
  assign anomaly_count_o    = CNT_OUT_W'(o_anom_q);
  assign frame_points_o     = CNT_OUT_W'(o_pts_q);
  assign frame_overflow_o   = o_ovf_q;

endmodule

[verif/tb_baseline_displacement_alarm_unit.sv]
// Self-checking testbench for the baseline displacement alarm unit.
module tb_baseline_displacement_alarm_unit;
  import bdal_pkg::*;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned MAX_PTS        = DEF_MAX_FRAME_POINTS;
  // Settle time after the last result: covers the reference division plus the close steps
  localparam int unsigned SETTLE_CYCLES  = 80;
  // Long receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_OFF_LONG  = 300;
  localparam int unsigned MAX_REPORTS    = 200;
  localparam int unsigned TIMEOUT_CYCLES = 850_000;

  // One point channel item
  typedef struct packed {
    logic                         req;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         last;
  } point_item_t;

  // One frame result item
  typedef struct packed {
    alarm_event_e                 evt;
    logic                         active;
    logic                         done;
    logic signed [COORD_BITS-1:0] ref_h;
    logic [COORD_BITS-1:0]        max_disp;
    logic signed [COORD_BITS-1:0] wx;
    logic signed [COORD_BITS-1:0] wy;
    logic signed [COORD_BITS-1:0] wz;
    logic [CNT_OUT_W-1:0]         anom;
    logic [CNT_OUT_W-1:0]         pts;
    logic                         ovf;
  } frame_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i;
  logic [CFG_DATA_W-1:0]        cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         req_type_i;
  logic signed [COORD_BITS-1:0] point_x_i;
  logic signed [COORD_BITS-1:0] point_y_i;
  logic signed [COORD_BITS-1:0] point_z_i;
  logic                         last_in_frame_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [1:0]                   alarm_event_o;
  logic                         alarm_active_o;
  logic                         baseline_done_o;
  logic signed [COORD_BITS-1:0] reference_height_o;
  logic [COORD_BITS-1:0]        frame_max_disp_o;
  logic signed [COORD_BITS-1:0] worst_x_o;
  logic signed [COORD_BITS-1:0] worst_y_o;
  logic signed [COORD_BITS-1:0] worst_z_o;
  logic [CNT_OUT_W-1:0]         anomaly_count_o;
  logic [CNT_OUT_W-1:0]         frame_points_o;
  logic                         frame_overflow_o;

  baseline_displacement_alarm_unit #(
    .MAX_FRAME_POINTS(MAX_PTS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .point_x_i          (point_x_i),
    .point_y_i          (point_y_i),
    .point_z_i          (point_z_i),
    .last_in_frame_i    (last_in_frame_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .alarm_event_o      (alarm_event_o),
    .alarm_active_o     (alarm_active_o),
    .baseline_done_o    (baseline_done_o),
    .reference_height_o (reference_height_o),
    .frame_max_disp_o   (frame_max_disp_o),
    .worst_x_o          (worst_x_o),
    .worst_y_o          (worst_y_o),
    .worst_z_o          (worst_z_o),
    .anomaly_count_o    (anomaly_count_o),
    .frame_points_o     (frame_points_o),
    .frame_overflow_o   (frame_overflow_o)
  );

  // ---------------------------------------------------------------------------------------
  // Stimulus and expectation stores
  // ---------------------------------------------------------------------------------------
  point_item_t   point_items_q[$];   // items waiting to be offered
  frame_result_t frame_results_q[$]; // predicted frame results, oldest first
  point_item_t   offered;            // item currently on the point channel
  frame_result_t exp_r;

  bit          in_taken;     // set on the edge that accepts the offered item
  int unsigned in_gap;       // idle cycles before the next item is offered
  int unsigned in_calm;      // cycles left in a stretch without sender idling
  int unsigned out_hold;     // cycles left with out_ready_i held low
  int unsigned out_calm;     // cycles left in a stretch without receiver idling
  bit          hold_req;     // ask the receiver for a long hold-off
  int unsigned results_seen;
  int unsigned mismatches;

  // ---------------------------------------------------------------------------------------
  // Alarm predictor: own copy of the registers and the frame/baseline state
  // ---------------------------------------------------------------------------------------
  logic [COORD_BITS-1:0] cfg_thresh;
  logic [PERMILLE_W-1:0] cfg_trig_pm;
  logic [PERMILLE_W-1:0] cfg_clr_pm;
  logic [3:0]            cfg_debounce;
  logic [7:0]            cfg_bl_frames;

  bit                           bl_ready;
  int unsigned                  bl_frames_seen;
  longint                       bl_sum;
  int unsigned                  bl_points;
  longint                       ref_z;
  bit                           alarm_on;
  int unsigned                  trig_run;
  int unsigned                  clr_run;
  int unsigned                  frm_points;
  int unsigned                  frm_anoms;
  longint                       frm_max_disp;
  logic signed [COORD_BITS-1:0] frm_wx;
  logic signed [COORD_BITS-1:0] frm_wy;
  logic signed [COORD_BITS-1:0] frm_wz;
  bit                           frm_ovf;

  function automatic void clear_frame();
    frm_points   = 0;
    frm_anoms    = 0;
    frm_max_disp = 0;
    frm_wx       = '0;
    frm_wy       = '0;
    frm_wz       = '0;
    frm_ovf      = 1'b0;
  endfunction

  function automatic void clear_alarm_state();
    bl_ready       = 1'b0;
    bl_frames_seen = 0;
    bl_sum         = 0;
    bl_points      = 0;
    ref_z          = 0;
    alarm_on       = 1'b0;
    trig_run       = 0;
    clr_run        = 0;
    clear_frame();
  endfunction

  // Advance the alarm state by one accepted item; queue a frame result on a frame close
  function automatic void track_point(input point_item_t it);
    longint        dev;
    longint        disp;
    longint        anom_scaled;
    int unsigned   need;
    int unsigned   deb;
    frame_result_t r;
    if (it.req == REQ_REBASELINE) begin
      clear_alarm_state();
      return;
    end
    // A point beyond the frame capacity is dropped but still flags overflow
    if (frm_points >= MAX_PTS) begin
      frm_ovf = 1'b1;
    end else begin
      frm_points++;
      if (!bl_ready) begin
        bl_sum += longint'(it.z);
        bl_points++;
      end else begin
        dev  = longint'(it.z) - ref_z;
        disp = (dev < 0) ? -dev : dev;
        if (disp > longint'(cfg_thresh)) begin
          frm_anoms++;
          // Strictly greater: the first point of equal displacement is kept
          if (disp > frm_max_disp) begin
            frm_max_disp = disp;
            frm_wx       = it.x;
            frm_wy       = it.y;
            frm_wz       = it.z;
          end
        end
      end
    end
    if (!it.last) return;

    r.evt = EVT_NONE;
    if (!bl_ready) begin
      need = (cfg_bl_frames == 0) ? 1 : cfg_bl_frames;
      if (bl_frames_seen < 255) bl_frames_seen++;
      if (bl_frames_seen >= need) begin
        // Signed division truncates toward zero
        ref_z    = (bl_points != 0) ? bl_sum / longint'(bl_points) : 0;
        bl_ready = 1'b1;
      end
      frm_anoms    = 0;
      frm_max_disp = 0;
      frm_wx       = '0;
      frm_wy       = '0;
      frm_wz       = '0;
    end else begin
      deb         = (cfg_debounce == 0) ? 1 : cfg_debounce;
      anom_scaled = longint'(frm_anoms) * 1000;
      if (anom_scaled > longint'(cfg_trig_pm) * longint'(frm_points))
        trig_run = (trig_run < 15) ? trig_run + 1 : 15;
      else
        trig_run = 0;
      if (anom_scaled < longint'(cfg_clr_pm) * longint'(frm_points))
        clr_run = (clr_run < 15) ? clr_run + 1 : 15;
      else
        clr_run = 0;
      if (!alarm_on && trig_run >= deb) begin
        alarm_on = 1'b1;
        r.evt    = EVT_RAISED;
      end
      // Raise and clear may both happen in one frame; the clear wins
      if (alarm_on && clr_run >= deb) begin
        alarm_on = 1'b0;
        r.evt    = EVT_CLEARED;
      end
    end
    r.active   = alarm_on;
    r.done     = bl_ready;
    r.ref_h    = ref_z[COORD_BITS-1:0];
    r.max_disp = frm_max_disp[COORD_BITS-1:0];
    r.wx       = frm_wx;
    r.wy       = frm_wy;
    r.wz       = frm_wz;
    r.anom     = frm_anoms[CNT_OUT_W-1:0];
    r.pts      = frm_points[CNT_OUT_W-1:0];
    r.ovf      = frm_ovf;
    frame_results_q.push_back(r);
    clear_frame();
  endfunction

  // ---------------------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------------------
  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int sat_coord(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] exp_v,
                                      input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic queue_point(input logic req, input int x, input int y, input int z,
                             input logic last);
    point_item_t it;
    it.req  = req;
    it.x    = x[COORD_BITS-1:0];
    it.y    = y[COORD_BITS-1:0];
    it.z    = z[COORD_BITS-1:0];
    it.last = last;
    point_items_q.push_back(it);
  endtask

  // Wait until every item is taken and every result is back, then let the block settle
  task automatic drain();
    while (point_items_q.size() != 0 || in_valid_i || frame_results_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DISP_THRESHOLD:   cfg_thresh    = val[COORD_BITS-1:0];
      REG_TRIGGER_PERMILLE: cfg_trig_pm   = val[PERMILLE_W-1:0];
      REG_CLEAR_PERMILLE:   cfg_clr_pm    = val[PERMILLE_W-1:0];
      REG_DEBOUNCE_FRAMES:  cfg_debounce  = val[3:0];
      REG_BASELINE_FRAMES:  cfg_bl_frames = val[7:0];
      default: ;
    endcase
  endtask

  // Drain the block, then rewrite every register
  task automatic set_regs(input int unsigned thr, input int unsigned trig,
                          input int unsigned clr, input int unsigned deb,
                          input int unsigned blf);
    drain();
    write_reg(REG_DISP_THRESHOLD, thr);
    write_reg(REG_TRIGGER_PERMILLE, trig);
    write_reg(REG_CLEAR_PERMILLE, clr);
    write_reg(REG_DEBOUNCE_FRAMES, deb);
    write_reg(REG_BASELINE_FRAMES, blf);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Queue a rebaseline, the baseline frames, then evaluated frames whose anomaly share
  // wanders between levels, so that the debounce runs build up and break.
  // Now and then a frame is cut short by a rebaseline, and a few points are pure noise.
  task automatic queue_stream(input int thr, input int blf, input int bl_pts_max,
                              input int n_items);
    int center;
    int added;
    int bl_left;
    int npts;
    int pct;
    int k;
    int zoff;
    int z;
    bit cut;
    center = $urandom_range(0, 40000) - 20000;
    added  = 0;
    pct    = 0;
    queue_point(REQ_REBASELINE, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    bl_left = (blf == 0) ? 1 : blf;
    while (added < n_items || bl_left > 0) begin
      if (bl_left > 0) begin
        npts = $urandom_range(1, bl_pts_max);
      end else begin
        npts = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 4))
            0:       pct = 0;
            1:       pct = 5;
            2:       pct = 30;
            3:       pct = 60;
            default: pct = 100;
          endcase
        end
      end
      cut = 1'b0;
      for (k = 0; k < npts && !cut; k++) begin
        if (bl_left == 0 && $urandom_range(0, 29) == 0) begin
          z = $urandom_range(0, 65535) - 32768;
        end else begin
          if (bl_left == 0 && $urandom_range(0, 99) < pct)
            zoff = thr + 1 + thr / 2 + $urandom_range(0, 2000);
          else
            zoff = $urandom_range(0, thr / 2);
          z = sat_coord($urandom_range(0, 1) ? center + zoff : center - zoff);
        end
        if ($urandom_range(0, 399) == 0) begin
          // drop the partial frame and restart the baseline
          queue_point(REQ_REBASELINE, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
          bl_left = (blf == 0) ? 1 : blf;
          cut     = 1'b1;
        end else begin
          queue_point(REQ_POINT, $urandom, $urandom, z, k == npts - 1);
          if (bl_left == 0) added++;
        end
      end
      if (bl_left > 0 && !cut) bl_left--;
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Clock, reset and known values on every input from time zero
  // ---------------------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_POINT;
    point_x_i       = '0;
    point_y_i       = '0;
    point_z_i       = '0;
    last_in_frame_i = 1'b0;
    out_ready_i     = 1'b0;
    in_taken        = 1'b0;
    in_gap          = 0;
    in_calm         = 0;
    out_hold        = 0;
    out_calm        = 0;
    hold_req        = 1'b0;
    results_seen    = 0;
    mismatches      = 0;
    offered         = '0;
    cfg_thresh      = RST_DISP_THRESHOLD;
    cfg_trig_pm     = RST_TRIGGER_PERMILLE;
    cfg_clr_pm      = RST_CLEAR_PERMILLE;
    cfg_debounce    = RST_DEBOUNCE_FRAMES;
    cfg_bl_frames   = RST_BASELINE_FRAMES;
    clear_alarm_state();
  end

  // ---------------------------------------------------------------------------------------
  // Point driver: offer items at the falling edge, hold each until it is taken
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (in_calm > 0) in_calm--;
    else if ($urandom_range(0, 199) == 0) in_calm = $urandom_range(50, 200);
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (point_items_q.size() > 0) begin
        offered          = point_items_q.pop_front();
        in_valid_i      <= 1'b1;
        req_type_i      <= offered.req;
        point_x_i       <= offered.x;
        point_y_i       <= offered.y;
        point_z_i       <= offered.z;
        last_in_frame_i <= offered.last;
        in_gap           = (in_calm > 0) ? 0 : idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Advance the predictor on each accepted item
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      track_point(offered);
      in_taken = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result receiver: random back-pressure, plus a long hold-off on request
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (out_calm > 0) out_calm--;
    else if ($urandom_range(0, 199) == 0) out_calm = $urandom_range(50, 200);
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      // hold off long enough for the block to fill up and stall its input
      hold_req     = 1'b0;
      out_hold     = HOLD_OFF_LONG;
      out_ready_i <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready_i <= 1'b0;
    end else if (out_calm > 0 || $urandom_range(0, 3) != 0) begin
      out_ready_i <= 1'b1;
    end else begin
      out_hold     = idle_len();
      out_ready_i <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_results_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected result item, expected none, actual event %0d",
                   $time, alarm_event_o);
        mismatches++;
      end else begin
        exp_r = frame_results_q.pop_front();
        check_field("alarm_event", exp_r.evt, alarm_event_o);
        check_field("alarm_active", exp_r.active, alarm_active_o);
        check_field("baseline_done", exp_r.done, baseline_done_o);
        check_field("reference_height", exp_r.ref_h, reference_height_o);
        check_field("frame_max_disp", exp_r.max_disp, frame_max_disp_o);
        check_field("worst_x", exp_r.wx, worst_x_o);
        check_field("worst_y", exp_r.wy, worst_y_o);
        check_field("worst_z", exp_r.wz, worst_z_o);
        check_field("anomaly_count", exp_r.anom, anomaly_count_o);
        check_field("frame_points", exp_r.pts, frame_points_o);
        check_field("frame_overflow", exp_r.ovf, frame_overflow_o);
      end
      results_seen++;
      if (results_seen == 30 || results_seen == 400) hold_req = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // One-frame baseline over extreme heights; the sum is negative so truncation toward
    // zero matters (-5 / 3 gives -1)
    set_regs(1000, 200, 100, 1, 1);
    queue_point(REQ_POINT, 32767, -32768, 32767, 1'b0);
    queue_point(REQ_POINT, -32768, 32767, -32768, 1'b0);
    queue_point(REQ_POINT, 0, 0, -4, 1'b1);
    // Two anomalies of equal displacement (first one kept), one exactly at the threshold
    queue_point(REQ_POINT, 1, 2, -1, 1'b0);
    queue_point(REQ_POINT, 3, 4, 1999, 1'b0);
    queue_point(REQ_POINT, 5, 6, -2001, 1'b0);
    queue_point(REQ_POINT, 7, 8, 999, 1'b1);
    // Largest displacements either side while the alarm is held
    queue_point(REQ_POINT, 9, 10, 32767, 1'b1);
    queue_point(REQ_POINT, -1, -1, -32768, 1'b1);
    // Quiet frame clears the alarm
    queue_point(REQ_POINT, 0, 0, 0, 1'b0);
    queue_point(REQ_POINT, 0, 0, -1, 1'b1);
    // Rebaseline in mid-frame drops the partial frame
    queue_point(REQ_POINT, 1, 1, 5, 1'b0);
    queue_point(REQ_REBASELINE, -1, 1, 7, 1'b1);
    queue_point(REQ_POINT, 0, 0, 100, 1'b1);
    queue_point(REQ_POINT, 2, 2, 100, 1'b1);

    // Zero debounce and zero baseline length; clear level above trigger level, so one
    // frame can raise and clear the alarm at once
    set_regs(0, 0, 1000, 0, 0);
    queue_point(REQ_REBASELINE, 0, 0, 0, 1'b0);
    queue_point(REQ_POINT, 0, 0, -300, 1'b1);
    queue_point(REQ_POINT, 4, 4, -295, 1'b0);
    queue_point(REQ_POINT, 5, 5, -300, 1'b1);
    queue_point(REQ_POINT, 6, 6, -305, 1'b1);

    // Random phases across several register settings, extremes included
    set_regs(300, 100, 50, 2, 3);
    queue_stream(300, 3, 4, 100);

    set_regs(0, 0, 0, 1, 2);
    queue_stream(0, 2, 3, 100);

    set_regs(65535, 1000, 1000, 15, 255);
    queue_stream(65535, 255, 1, 100);

    set_regs(2000, 300, 600, 4, 5);
    queue_stream(2000, 5, 4, 100);

    begin : rand_cfg_b
      int unsigned thr;
      int unsigned blf;
      thr = $urandom_range(0, 8000);
      blf = $urandom_range(0, 8);
      set_regs(thr, $urandom_range(0, 1000), $urandom_range(0, 1000), $urandom_range(0, 15),
               blf);
      queue_stream(thr, blf, 4, 100);
    end

    set_regs(RST_DISP_THRESHOLD + 1000, RST_TRIGGER_PERMILLE, RST_CLEAR_PERMILLE,
             RST_DEBOUNCE_FRAMES, RST_BASELINE_FRAMES);
    queue_stream(1000, RST_BASELINE_FRAMES, 2, 100);

    drain();
    if (mismatches == 0 && frame_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("simulation failed");
    $finish;
  end

endmodule
